/* design/pcbp_pkg.sv */
package pcbp_pkg;

  // Alphabet and byte geometry.
  localparam int NUM_SYMBOLS       = 29;
  localparam int BYTE_BITS         = 8;
  localparam int STORE_LEN_LIMIT   = 16;
  localparam int PCBP_MAX_CODE_LEN = 16;
  localparam int SYM_W             = 5;
  localparam int PEND_W            = BYTE_BITS - 1;
  localparam int PCNT_W            = 3;

  // Symbol codes for the punctuation marks.
  localparam logic [SYM_W-1:0] SYM_SPACE  = 5'd26;
  localparam logic [SYM_W-1:0] SYM_COMMA  = 5'd27;
  localparam logic [SYM_W-1:0] SYM_PERIOD = 5'd28;

  // Character bytes that map into the alphabet.
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_COMMA   = 8'h2c;
  localparam logic [7:0] CHAR_PERIOD  = 8'h2e;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DATA    = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_NO_CODE = 2'd2
  } status_t;

  // Lookup result of a character: a hit flag and the symbol code.
  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] idx;
  } sym_lookup_t;

  function automatic sym_lookup_t pcbp_symbol(input logic [7:0] ch);
    sym_lookup_t res;
    logic [7:0]  diff;
    res  = '0;
    diff = ch - CHAR_LOWER_A;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      res.ok  = 1'b1;
      res.idx = diff[SYM_W-1:0];
    end else if (ch == CHAR_SPACE) begin
      res.ok  = 1'b1;
      res.idx = SYM_SPACE;
    end else if (ch == CHAR_COMMA) begin
      res.ok  = 1'b1;
      res.idx = SYM_COMMA;
    end else if (ch == CHAR_PERIOD) begin
      res.ok  = 1'b1;
      res.idx = SYM_PERIOD;
    end
    return res;
  endfunction

endpackage

/* design/pcbp_if.sv */
// Command channel: one word per load, encode or finish command.
interface pcbp_in_if import pcbp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  char_in;
  logic [4:0]  entry_index;
  logic [15:0] entry_bits;
  logic [4:0]  entry_length;

  modport source (output valid, cmd, char_in, entry_index, entry_bits, entry_length,
                  input ready);
  modport sink   (input valid, cmd, char_in, entry_index, entry_bits, entry_length,
                  output ready);
endinterface

// Result channel: one packed byte or error report per word.
interface pcbp_out_if import pcbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input valid, out_byte, status, last, output ready);
endinterface

/* design/pcbp_codebook.sv */
module pcbp_codebook import pcbp_pkg::*; #(
  parameter int CODE_W = PCBP_MAX_CODE_LEN,
  parameter int LEN_W  = $clog2(PCBP_MAX_CODE_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [SYM_W-1:0]  wr_addr,
  input  logic [CODE_W-1:0] wr_bits,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              rd_en,
  input  logic [SYM_W-1:0]  rd_addr,
  output logic              rd_valid,
  output logic [CODE_W-1:0] rd_bits,
  output logic [LEN_W-1:0]  rd_len
);

  logic [CODE_W-1:0]      bits_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]       len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid_r;
  logic                   rd_valid_r;
  logic [CODE_W-1:0]      rd_bits_r;
  logic [LEN_W-1:0]       rd_len_r;

  // Codeword and length storage, no reset: only read behind a valid mark.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bits_mem[wr_addr] <= wr_bits;
      len_mem[wr_addr]  <= wr_len;
    end
    if (rd_en) begin
      rd_bits_r <= bits_mem[rd_addr];
      rd_len_r  <= len_mem[rd_addr];
    end
  end

  // Valid marks are cleared at reset and set by each load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_bits  = rd_bits_r;
  assign rd_len   = rd_len_r;

endmodule

/* design/prefix_code_bit_packer_unit.sv */
// Prefix-code bit packer.
// The in_ch channel carries command words: load writes one codebook slot,
// encode appends the codeword of a character MSB first to the pending
// partial byte, finish pads the pending bits with a 1 and zeros (0x80 when
// nothing is pending) and closes the stream. The out_ch channel carries
// result words: packed bytes, or one error word for a character outside the
// alphabet or a symbol with no codeword; last marks the final word of a
// command. An encode reads the codebook, then a one-bit shifter moves the
// codeword into the byte register one bit per cycle, save where a completed
// byte waits for the output register. A character outside the alphabet goes
// straight to the error word, a symbol with no codeword reaches it after the
// codebook read. in_ch.ready is high only while no command is in work.
// Results sit in one output register; when the receiver stalls, the shifter
// waits at each completed byte until that register frees up.
// Reset clears the codebook valid marks, the pending bits and the output.
module prefix_code_bit_packer_unit import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = PCBP_MAX_CODE_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  pcbp_in_if.sink     in_ch,
  pcbp_out_if.source  out_ch
);

  localparam int CODE_W = (MAX_CODE_LEN < STORE_LEN_LIMIT) ? MAX_CODE_LEN : STORE_LEN_LIMIT;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int IDX_W  = (CODE_W > 1) ? $clog2(CODE_W) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_ERR,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  status_t            err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  sym_lookup_t        sym;
  logic               wr_en;
  logic [LEN_W-1:0]   len_sat;
  logic [CODE_W-1:0]  bits_masked;
  logic               rd_en;
  logic               rd_valid;
  logic [CODE_W-1:0]  rd_bits;
  logic [LEN_W-1:0]   rd_len;
  logic               out_free;
  logic [LEN_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   bit_idx;
  logic               code_bit;
  logic [7:0]         fin_ext;
  logic [7:0]         fin_byte;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign sym         = pcbp_symbol(in_ch.char_in);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Load path: saturate the length and drop codeword bits above it.
  always_comb begin
    if (in_ch.entry_length > LEN_W'(CODE_W) && 5'(CODE_W) < in_ch.entry_length) begin
      len_sat = LEN_W'(CODE_W);
    end else begin
      len_sat = LEN_W'(in_ch.entry_length);
    end
    for (int i = 0; i < CODE_W; i++) begin
      bits_masked[i] = in_ch.entry_bits[i] && (LEN_W'(i) < len_sat);
    end
  end

  assign wr_en = accept && (cmd_t'(in_ch.cmd) == CMD_LOAD)
                 && (in_ch.entry_index < 5'(NUM_SYMBOLS));
  assign rd_en = accept && (cmd_t'(in_ch.cmd) == CMD_ENCODE) && sym.ok;

  pcbp_codebook #(
    .CODE_W (CODE_W),
    .LEN_W  (LEN_W)
  ) u_codebook (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (in_ch.entry_index),
    .wr_bits  (bits_masked),
    .wr_len   (len_sat),
    .rd_en    (rd_en),
    .rd_addr  (sym.idx),
    .rd_valid (rd_valid),
    .rd_bits  (rd_bits),
    .rd_len   (rd_len)
  );

  // Next codeword bit, taken MSB first as the count runs down.
  assign cnt_m1   = cnt_r - 1'b1;
  assign bit_idx  = IDX_W'(cnt_m1);
  assign code_bit = rd_bits[bit_idx];

  // Finish byte: pending bits, a 1, then zeros; bits above the count drop out.
  assign fin_ext  = {pend_r, 1'b1};
  assign fin_byte = fin_ext << (3'd7 - pcnt_r);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pcnt_nxt       = pcnt_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_ch.cmd))
            CMD_ENCODE: begin
              if (sym.ok) begin
                state_nxt = S_CHECK;
              end else begin
                err_nxt   = STAT_OUTSIDE;
                state_nxt = S_ERR;
              end
            end
            CMD_FINISH: state_nxt = S_FIN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        cnt_nxt = rd_len;
        if (!rd_valid) begin
          err_nxt   = STAT_NO_CODE;
          state_nxt = S_ERR;
        end else if (rd_len == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // A completed byte waits here until the output register is free.
        if (pcnt_r != 3'd7 || out_free) begin
          cnt_nxt = cnt_m1;
          if (pcnt_r == 3'd7) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = {pend_r, code_bit};
            out_status_nxt = STAT_DATA;
            // This byte is the last one when less than a byte of code remains.
            out_last_nxt   = (int'(cnt_r) <= BYTE_BITS);
            pend_nxt       = '0;
            pcnt_nxt       = '0;
          end else begin
            pend_nxt = {pend_r[PEND_W-2:0], code_bit};
            pcnt_nxt = pcnt_r + 1'b1;
          end
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_status_nxt = err_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = fin_byte;
          out_status_nxt = STAT_DATA;
          out_last_nxt   = 1'b1;
          pend_nxt       = '0;
          pcnt_nxt       = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r        <= cnt_nxt;
    err_r        <= err_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  // An error word always closes its command and carries a zero byte.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_DATA |-> out_last_r && out_byte_r == '0)
    else $error("error word without last or with nonzero byte");

  // A character outside the alphabet goes straight to error reporting.
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd_t'(in_ch.cmd) == CMD_ENCODE && !sym.ok |=> state_r == S_ERR)
    else $error("outside character not reported");

  // The shifter never runs with an empty bit count.
  a_shift_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> cnt_r != '0)
    else $error("shift state with zero count");

  // A finish leaves no pending bits behind once its word is out.
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> pcnt_r == '0 && out_valid_r && out_last_r)
    else $error("finish did not clear pending bits");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcbp_pkg::*;

  // The block has no opcode for value 3; it must be dropped without a word.
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         CODE_LEN_CAP = (PCBP_MAX_CODE_LEN < STORE_LEN_LIMIT) ?
                                        PCBP_MAX_CODE_LEN : STORE_LEN_LIMIT;
  localparam int         RANDOM_ITEMS   = 700;
  localparam int         HOLD_START     = 1500;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [4:0]  slot;
    logic [15:0] code;
    logic [4:0]  code_len;
  } cmd_word_t;

  typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_word_t;

  logic clk;
  logic rst_n;

  pcbp_in_if  in_if();
  pcbp_out_if out_if();

  prefix_code_bit_packer_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Shadow copy of the codebook and the partial byte.
  logic [15:0] code_word [NUM_SYMBOLS];
  logic [4:0]  code_len [NUM_SYMBOLS];
  logic        code_loaded [NUM_SYMBOLS];
  logic [6:0]  carry_bits;
  int          carry_cnt;

  cmd_word_t    cmd_pending[$];
  result_word_t byte_expect[$];
  cmd_word_t    on_bus;

  int errors;
  int planned;
  int words_seen;
  int error_words;
  int n_load, n_encode, n_finish;
  int gap_left;
  bit quiet_in;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int char_symbol(input logic [7:0] ch);
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) return int'(ch - CHAR_LOWER_A);
    if (ch == CHAR_SPACE) return int'(SYM_SPACE);
    if (ch == CHAR_COMMA) return int'(SYM_COMMA);
    if (ch == CHAR_PERIOD) return int'(SYM_PERIOD);
    return -1;
  endfunction

  function automatic logic [7:0] symbol_char(input int s);
    if (s < 26) return CHAR_LOWER_A + 8'(s);
    if (s == int'(SYM_SPACE)) return CHAR_SPACE;
    if (s == int'(SYM_COMMA)) return CHAR_COMMA;
    return CHAR_PERIOD;
  endfunction

  // The letter b, chosen so that a one-bit code is followed by a fresh slot.
  function automatic logic [7:0] CHAR_LOWER_B_SAFE();
    return CHAR_LOWER_A + 8'd1;
  endfunction

  task automatic push_result(input logic [7:0] data, input status_t st, input logic last);
    result_word_t r;
    r.data   = data;
    r.status = st;
    r.last   = last;
    byte_expect.push_back(r);
  endtask

  // Apply one accepted command to the shadow state and queue the words it yields.
  task automatic pack_command(input cmd_word_t w);
    int         s;
    int         acc;
    int         total;
    int         made;
    logic [4:0] len;
    case (w.op)
      CMD_LOAD: begin
        if (w.slot < NUM_SYMBOLS) begin
          len = w.code_len;
          if (len > CODE_LEN_CAP) len = 5'(CODE_LEN_CAP);
          code_word[w.slot]   = 16'(int'(w.code) & ((1 << len) - 1));
          code_len[w.slot]    = len;
          code_loaded[w.slot] = 1'b1;
          n_load++;
        end
      end
      CMD_ENCODE: begin
        n_encode++;
        s = char_symbol(w.ch);
        if (s < 0) begin
          push_result(8'h00, STAT_OUTSIDE, 1'b1);
          error_words++;
        end else if (!code_loaded[s]) begin
          push_result(8'h00, STAT_NO_CODE, 1'b1);
          error_words++;
        end else begin
          acc   = (int'(carry_bits) << code_len[s]) | int'(code_word[s]);
          total = carry_cnt + int'(code_len[s]);
          made  = 0;
          while (total >= BYTE_BITS) begin
            total -= BYTE_BITS;
            push_result(8'((acc >> total) & 8'hff), STAT_DATA, 1'b0);
            made++;
            acc &= (1 << total) - 1;
          end
          if (made > 0) byte_expect[byte_expect.size()-1].last = 1'b1;
          carry_bits = 7'(acc);
          carry_cnt  = total;
        end
      end
      CMD_FINISH: begin
        n_finish++;
        if (carry_cnt != 0)
          push_result(8'((int'(carry_bits) << (BYTE_BITS - carry_cnt)) |
                         (1 << (BYTE_BITS - 1 - carry_cnt))), STAT_DATA, 1'b1);
        else
          push_result(8'h80, STAT_DATA, 1'b1);
        carry_bits = '0;
        carry_cnt  = 0;
      end
      default: ;
    endcase
  endtask

  // Queue one command; dropped commands do not count toward the random budget.
  task automatic plan(input logic [1:0] op, input logic [7:0] ch, input logic [4:0] slot,
                      input logic [15:0] code, input logic [4:0] len);
    cmd_word_t w;
    w.op       = op;
    w.ch       = ch;
    w.slot     = slot;
    w.code     = code;
    w.code_len = len;
    cmd_pending.push_back(w);
    if (op != CMD_UNUSED && !(op == CMD_LOAD && slot >= NUM_SYMBOLS)) planned++;
  endtask

  // Driver: offers queued commands with random gaps between them.
  always @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      pack_command(on_bus);
      if ($urandom_range(0, 49) == 0) quiet_in = !quiet_in;
      if (quiet_in) gap_left = 0;
      else begin
        case ($urandom_range(0, 99)) inside
          [0:54]:  gap_left = 0;
          [55:89]: gap_left = $urandom_range(1, 3);
          default: gap_left = $urandom_range(8, 30);
        endcase
      end
    end
    if (rst_n && (!in_if.valid || in_if.ready)) begin
      if (gap_left == 0 && cmd_pending.size() > 0) begin
        on_bus = cmd_pending.pop_front();
        in_if.valid        <= 1'b1;
        in_if.cmd          <= on_bus.op;
        in_if.char_in      <= on_bus.ch;
        in_if.entry_index  <= on_bus.slot;
        in_if.entry_bits   <= on_bus.code;
        in_if.entry_length <= on_bus.code_len;
      end else begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off.
  always @(posedge clk) begin : receiver
    int  cycle_cnt;
    int  hold_left;
    int  stall_left;
    bit  quiet_out;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      cycle_cnt++;
      if ($urandom_range(0, 199) == 0) quiet_out = !quiet_out;
      if (cycle_cnt == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet_out) begin
          case ($urandom_range(0, 99)) inside
            [0:79]:  stall_left = 0;
            [80:94]: stall_left = $urandom_range(1, 3);
            default: stall_left = $urandom_range(8, 25);
          endcase
        end
      end
    end
  end

  // Monitor: every accepted word must match the oldest expected word.
  always @(posedge clk) begin : monitor
    result_word_t want;
    if (out_if.valid && out_if.ready) begin
      words_seen++;
      if (byte_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected word byte=%02h status=%0d last=%0b", $time,
                 out_if.out_byte, out_if.status, out_if.last);
      end else begin
        want = byte_expect.pop_front();
        if (out_if.out_byte !== want.data || out_if.status !== want.status ||
            out_if.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected byte=%02h status=%0d last=%0b,",
                   $time, want.data, want.status, want.last,
                   " got byte=%02h status=%0d last=%0b",
                   out_if.out_byte, out_if.status, out_if.last);
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL prefix_code_bit_packer_unit");
      $finish;
    end
  end

  initial begin
    int nchars;
    int sym;
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_FINISH;
    in_if.char_in      = '0;
    in_if.entry_index  = '0;
    in_if.entry_bits   = '0;
    in_if.entry_length = '0;
    out_if.ready       = 1'b0;
    rst_n              = 1'b0;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      code_word[i]   = '0;
      code_len[i]    = '0;
      code_loaded[i] = 1'b0;
    end
    carry_bits = '0;
    carry_cnt  = 0;

    // Errors on an empty codebook, and a finish with nothing pending.
    plan(CMD_ENCODE, CHAR_LOWER_A, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, 8'h00, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, 8'hff, 5'd31, 16'hffff, 5'd31);
    plan(CMD_ENCODE, CHAR_LOWER_A - 8'd1, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_LOWER_Z + 8'd1, 5'd0, 16'h0, 5'd0);
    plan(CMD_FINISH, 8'h0, 5'd0, 16'h0, 5'd0);
    // Loads: shortest and longest codes, zero length, an oversized length,
    // dropped upper bits, a slot past the alphabet and the unused opcode.
    plan(CMD_LOAD, 8'h0, 5'd0, 16'hfffd, 5'd1);
    plan(CMD_LOAD, 8'h0, 5'd25, 16'hffff, 5'd16);
    plan(CMD_LOAD, 8'h0, SYM_SPACE, 16'h1234, 5'd0);
    plan(CMD_LOAD, 8'h0, SYM_COMMA, 16'ha5c3, 5'd31);
    plan(CMD_LOAD, 8'h0, SYM_PERIOD, 16'hffaa, 5'd7);
    plan(CMD_LOAD, 8'hff, 5'd31, 16'h0001, 5'd3);
    plan(CMD_UNUSED, CHAR_LOWER_A, 5'd0, 16'hffff, 5'd16);
    // Encodes that fill two bytes, none, exactly one, and a padded finish.
    plan(CMD_ENCODE, CHAR_LOWER_Z, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_LOWER_A, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_SPACE, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_PERIOD, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_COMMA, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_LOWER_A, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_LOWER_Z, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_PERIOD, 5'd0, 16'h0, 5'd0);
    plan(CMD_FINISH, 8'h0, 5'd0, 16'h0, 5'd0);
    plan(CMD_ENCODE, CHAR_LOWER_B_SAFE(), 5'd0, 16'h0, 5'd0);
    plan(CMD_FINISH, 8'h0, 5'd0, 16'h0, 5'd0);

    // Random part: mostly messages of alphabet characters closed by a finish,
    // with codebook reloads and some noise in between.
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:14]: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 99)) inside
              [0:7]:   plan(CMD_LOAD, 8'($urandom), 5'($urandom_range(0, 28)),
                            16'($urandom), 5'd0);
              [8:15]:  plan(CMD_LOAD, 8'($urandom), 5'($urandom_range(0, 28)),
                            16'($urandom), 5'($urandom_range(17, 31)));
              default: plan(CMD_LOAD, 8'($urandom), 5'($urandom_range(0, 28)),
                            16'($urandom), 5'($urandom_range(1, 16)));
            endcase
          end
        end
        [15:84]: begin
          nchars = $urandom_range(1, 12);
          repeat (nchars) begin
            sym = int'($urandom_range(0, 28));
            if ($urandom_range(0, 19) == 0)
              plan(CMD_ENCODE, 8'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
            else
              plan(CMD_ENCODE, symbol_char(sym), 5'($urandom), 16'($urandom),
                   5'($urandom));
          end
          if ($urandom_range(0, 3) != 0)
            plan(CMD_FINISH, 8'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
        end
        [85:92]: begin
          case ($urandom_range(0, 2))
            0:       plan(CMD_UNUSED, 8'($urandom), 5'($urandom), 16'($urandom),
                          5'($urandom));
            1:       plan(CMD_LOAD, 8'($urandom), 5'($urandom_range(29, 31)),
                          16'($urandom), 5'($urandom));
            default: plan(CMD_ENCODE, 8'($urandom), 5'($urandom), 16'($urandom),
                          5'($urandom));
          endcase
        end
        default: plan(CMD_FINISH, 8'($urandom), 5'($urandom), 16'($urandom), 5'($urandom));
      endcase
    end
    plan(CMD_FINISH, 8'h0, 5'd0, 16'h0, 5'd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last command to go in and its words to come out.
    while (cmd_pending.size() != 0 || in_if.valid || byte_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d loads, %0d encodes and %0d finishes;", n_load, n_encode,
             n_finish);
    $display("%0d result words checked, %0d of them error reports.", words_seen, error_words);
    if (errors == 0 && byte_expect.size() == 0) begin
      $display("PASS prefix_code_bit_packer_unit");
    end else begin
      $display("%0d failures, %0d words never arrived", errors, byte_expect.size());
      $display("FAIL prefix_code_bit_packer_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pcbp_pkg.sv
design/pcbp_if.sv
design/pcbp_codebook.sv
design/prefix_code_bit_packer_unit.sv
tb/testbench.sv
